FILE: rtl/i2c_mts_pkg.sv
// ----------------------------------------------------------------------------
// i2c_mts_pkg
// Shared types and constants of the I2C master transfer sequencer: command
// codes, register indexes, event and error bit positions, header bytes.
// ----------------------------------------------------------------------------
package i2c_mts_pkg;

    // request command codes
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_EVENT  = 2'd1,
        CMD_ERROR  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_DIRECTION  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEN_BIT_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DMA_MODE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFER_LENGTH = 3'd4;

    // field widths
    localparam int unsigned ADDR_W   = 10;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned EVENTS_W = 6;
    localparam int unsigned ERRORS_W = 6;

    // event bit positions
    localparam int unsigned EV_ADDR    = 0;
    localparam int unsigned EV_TX      = 1;
    localparam int unsigned EV_RX      = 2;
    localparam int unsigned EV_IDLE    = 3;
    localparam int unsigned EV_IO_ERR  = 4;
    localparam int unsigned EV_INVALID = 5;

    // error bit positions; the bits below the ack failure are all i/o errors
    localparam int unsigned ERR_ACK_FAIL = 5;

    // 10-bit header bytes for write and read
    localparam logic [7:0] HDR_WRITE = 8'hF0;
    localparam logic [7:0] HDR_READ  = 8'hF1;

    // one result
    typedef struct packed {
        logic                write_data_reg;
        logic [7:0]          data_value;
        logic                store_rx;
        logic                took_tx;
        logic                request_stop;
        logic                drop_ack;
        logic                buffer_irq_on;
        logic [EVENTS_W-1:0] events;
        logic                handled;
    } result_t;

endpackage

FILE: rtl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Decodes I2C peripheral status and error flags into data register writes,
// stop and acknowledge control and transfer events for a master transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries one request: start, event or error,
//   with the peripheral flags, the received byte and the next byte to send.
//   m_* channel (valid/ready) returns exactly one result per request.
//   cfg_wr_en/cfg_index/cfg_data write the direction, addressing mode,
//   slave address, dma mode and transfer length; write only while idle.
// Timing:
//   a request is captured in the input register when accepted, the flag
//   decode and the remaining-count update run between it and the result
//   register, so each result is registered in the result register.
//   One request per cycle is sustained while m_ready stays high; the
//   remaining counter is the only loop.
// Reset:
//   aresetn low clears the valids, the remaining count and the configuration
//   registers.
// Stall:
//   while m_ready is low the result holds, the input register still takes
//   one more request, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
    import i2c_mts_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic                   s_start_sent,
    input  logic                   s_address_done,
    input  logic                   s_header_done,
    input  logic                   s_byte_finished,
    input  logic                   s_rx_not_empty,
    input  logic                   s_tx_empty,
    input  logic                   s_transmitter_role,
    input  logic [7:0]             s_rx_byte,
    input  logic [7:0]             s_next_tx_byte,
    input  logic [ERRORS_W-1:0]    s_error_bits,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_write_data_reg,
    output logic [7:0]             m_data_value,
    output logic                   m_store_rx,
    output logic                   m_took_tx,
    output logic                   m_request_stop,
    output logic                   m_drop_ack,
    output logic                   m_buffer_irq_on,
    output logic [EVENTS_W-1:0]    m_events,
    output logic                   m_handled
);

    // configuration registers
    logic               read_direction_reg;
    logic               ten_bit_mode_reg;
    logic [ADDR_W-1:0]  slave_address_reg;
    logic               dma_mode_reg;
    logic [COUNT_W-1:0] transfer_length_reg;

    // input register
    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic                in_start_sent_reg;
    logic                in_address_done_reg;
    logic                in_header_done_reg;
    logic                in_byte_finished_reg;
    logic                in_rx_not_empty_reg;
    logic                in_tx_empty_reg;
    logic                in_transmitter_role_reg;
    logic [7:0]          in_next_tx_byte_reg;
    logic [ERRORS_W-1:0] in_error_bits_reg;

    // state and result register
    logic [COUNT_W-1:0] remaining_reg;
    logic [COUNT_W-1:0] remaining_next;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic               advance;
    logic               go;
    logic               rem_zero;
    logic               rem_one;
    logic [COUNT_W-1:0] rem_dec;
    logic [7:0]         hdr_bits;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_direction_reg  <= 1'b0;
            ten_bit_mode_reg    <= 1'b0;
            slave_address_reg   <= '0;
            dma_mode_reg        <= 1'b0;
            transfer_length_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_READ_DIRECTION:  read_direction_reg  <= cfg_data[0];
                CFG_TEN_BIT_MODE:    ten_bit_mode_reg    <= cfg_data[0];
                CFG_SLAVE_ADDRESS:   slave_address_reg   <= cfg_data[ADDR_W-1:0];
                CFG_DMA_MODE:        dma_mode_reg        <= cfg_data[0];
                CFG_TRANSFER_LENGTH: transfer_length_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg              <= cmd_t'(s_cmd);
            in_start_sent_reg       <= s_start_sent;
            in_address_done_reg     <= s_address_done;
            in_header_done_reg      <= s_header_done;
            in_byte_finished_reg    <= s_byte_finished;
            in_rx_not_empty_reg     <= s_rx_not_empty;
            in_tx_empty_reg         <= s_tx_empty;
            in_transmitter_role_reg <= s_transmitter_role;
            in_next_tx_byte_reg     <= s_next_tx_byte;
            in_error_bits_reg       <= s_error_bits;
        end
    end

    // count helpers and 10-bit header address bits
    assign rem_zero = (remaining_reg == '0);
    assign rem_one  = (remaining_reg == COUNT_W'(1));
    assign rem_dec  = remaining_reg - COUNT_W'(1);
    assign hdr_bits = {5'd0, slave_address_reg[ADDR_W-1:ADDR_W-2], 1'b0};

    // flag decode, in the order the interrupt handler examines them
    always_comb begin
        result_next    = '0;
        remaining_next = remaining_reg;
        go             = 1'b1;
        unique case (in_cmd_reg)
            CMD_START: begin
                remaining_next = transfer_length_reg;
            end
            CMD_EVENT: begin
                if (read_direction_reg) begin
                    // master receive
                    if (in_start_sent_reg) begin
                        result_next.write_data_reg = 1'b1;
                        result_next.data_value = ten_bit_mode_reg ?
                            (HDR_READ | hdr_bits) : {slave_address_reg[7:1], 1'b1};
                    end
                    if (in_address_done_reg) begin
                        if (in_transmitter_role_reg) begin
                            result_next.events[EV_IO_ERR] = 1'b1;
                            go = 1'b0;
                        end else begin
                            if (rem_one) result_next.drop_ack = 1'b1;
                            if (!dma_mode_reg) begin
                                result_next.buffer_irq_on = 1'b1;
                            end else begin
                                result_next.events[EV_ADDR] = 1'b1;
                                result_next.handled = 1'b1;
                                go = 1'b0;
                            end
                        end
                    end
                    if (go && in_rx_not_empty_reg) begin
                        if (!rem_zero) begin
                            remaining_next       = rem_dec;
                            result_next.store_rx = 1'b1;
                            if (rem_one) begin
                                result_next.drop_ack        = 1'b1;
                                result_next.events[EV_RX]   = 1'b1;
                                result_next.events[EV_IDLE] = 1'b1;
                            end
                        end
                        if (rem_zero || rem_one) result_next.request_stop = 1'b1;
                        result_next.handled = 1'b1;
                        go = 1'b0;
                    end
                    if (go && in_byte_finished_reg) begin
                        if (!rem_zero) begin
                            result_next.store_rx = 1'b1;
                        end else begin
                            result_next.events[EV_RX] = 1'b1;
                            result_next.handled = 1'b1;
                            go = 1'b0;
                        end
                    end
                    if (go && in_tx_empty_reg) begin
                        result_next.events[EV_INVALID] = 1'b1;
                        result_next.handled = 1'b1;
                        go = 1'b0;
                    end
                    if (go && in_header_done_reg) begin
                        result_next.write_data_reg = 1'b1;
                        result_next.data_value     = slave_address_reg[7:0];
                    end
                end else begin
                    // master transmit
                    if (in_start_sent_reg) begin
                        result_next.write_data_reg = 1'b1;
                        result_next.data_value = ten_bit_mode_reg ?
                            (HDR_WRITE | hdr_bits) : {slave_address_reg[7:1], 1'b0};
                    end
                    if (in_rx_not_empty_reg) begin
                        result_next.events[EV_INVALID] = 1'b1;
                        result_next.handled = 1'b1;
                        go = 1'b0;
                    end
                    if (go && in_address_done_reg) begin
                        if (!in_transmitter_role_reg) begin
                            result_next.events[EV_IO_ERR] = 1'b1;
                            go = 1'b0;
                        end else if (!dma_mode_reg) begin
                            result_next.buffer_irq_on = 1'b1;
                        end else begin
                            result_next.events[EV_ADDR] = 1'b1;
                            result_next.handled = 1'b1;
                            go = 1'b0;
                        end
                    end
                    if (go && in_byte_finished_reg &&
                        ((in_tx_empty_reg && rem_zero) || dma_mode_reg)) begin
                        result_next.request_stop    = 1'b1;
                        result_next.events[EV_IDLE] = 1'b1;
                        result_next.handled = 1'b1;
                        go = 1'b0;
                    end
                    if (go && in_tx_empty_reg) begin
                        if (!rem_zero) begin
                            remaining_next = rem_dec;
                            result_next.write_data_reg = 1'b1;
                            result_next.data_value     = in_next_tx_byte_reg;
                            result_next.took_tx        = 1'b1;
                        end else begin
                            result_next.events[EV_TX] = 1'b1;
                            result_next.handled = 1'b1;
                            go = 1'b0;
                        end
                    end
                    if (go && in_header_done_reg) begin
                        result_next.write_data_reg = 1'b1;
                        result_next.data_value     = slave_address_reg[7:0];
                    end
                end
            end
            CMD_ERROR: begin
                if (|in_error_bits_reg[ERR_ACK_FAIL-1:0]) begin
                    result_next.events[EV_IO_ERR] = 1'b1;
                    result_next.handled = 1'b1;
                end else if (in_error_bits_reg[ERR_ACK_FAIL]) begin
                    result_next.request_stop    = 1'b1;
                    result_next.events[EV_IDLE] = 1'b1;
                    result_next.handled = 1'b1;
                end
            end
            CMD_UNUSED: ;
        endcase
    end

    // remaining count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) remaining_reg <= remaining_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) result_reg <= result_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_write_data_reg = result_reg.write_data_reg;
    assign m_data_value     = result_reg.data_value;
    assign m_store_rx       = result_reg.store_rx;
    assign m_took_tx        = result_reg.took_tx;
    assign m_request_stop   = result_reg.request_stop;
    assign m_drop_ack       = result_reg.drop_ack;
    assign m_buffer_irq_on  = result_reg.buffer_irq_on;
    assign m_events         = result_reg.events;
    assign m_handled        = result_reg.handled;

endmodule

FILE: tb/i2c_master_transfer_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_tb
// Self-checking bench for the I2C master transfer sequencer. A queue-fed
// driver sends start, event, error and unused requests with random gaps. A
// monitor takes responses under random back-pressure and compares each one,
// field by field, with the response that the bench's own flag decoder
// predicts. The bench runs a directed opening and then random transfers over
// many register settings.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_tb;
    import i2c_mts_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_ITEMS  = 105;
    localparam int CALM_PHASES  = 3;

    // status flag masks, in the order {start, addr, header, byte, rxne, txe, role}
    localparam logic [6:0] FL_START_SENT = 7'h40;
    localparam logic [6:0] FL_ADDR_DONE  = 7'h20;
    localparam logic [6:0] FL_HDR_DONE   = 7'h10;
    localparam logic [6:0] FL_BYTE_FIN   = 7'h08;
    localparam logic [6:0] FL_RX_NE      = 7'h04;
    localparam logic [6:0] FL_TX_EMPTY   = 7'h02;
    localparam logic [6:0] FL_XMIT_ROLE  = 7'h01;
    localparam logic [6:0] FL_NONE       = 7'h00;

    localparam logic [ERRORS_W-1:0] ERR_ACK_MASK = ERRORS_W'(1) << ERR_ACK_FAIL;
    localparam logic [ERRORS_W-1:0] ERR_IO_MASK  = ERR_ACK_MASK - ERRORS_W'(1);

    typedef struct {
        cmd_t                cmd;
        logic                start_sent;
        logic                address_done;
        logic                header_done;
        logic                byte_finished;
        logic                rx_not_empty;
        logic                tx_empty;
        logic                transmitter_role;
        logic [7:0]          rx_byte;
        logic [7:0]          next_tx_byte;
        logic [ERRORS_W-1:0] error_bits;
    } xfer_req_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                s_valid            = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd              = '0;
    logic                s_start_sent       = 1'b0;
    logic                s_address_done     = 1'b0;
    logic                s_header_done      = 1'b0;
    logic                s_byte_finished    = 1'b0;
    logic                s_rx_not_empty     = 1'b0;
    logic                s_tx_empty         = 1'b0;
    logic                s_transmitter_role = 1'b0;
    logic [7:0]          s_rx_byte          = '0;
    logic [7:0]          s_next_tx_byte     = '0;
    logic [ERRORS_W-1:0] s_error_bits       = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_write_data_reg;
    logic [7:0]          m_data_value;
    logic                m_store_rx;
    logic                m_took_tx;
    logic                m_request_stop;
    logic                m_drop_ack;
    logic                m_buffer_irq_on;
    logic [EVENTS_W-1:0] m_events;
    logic                m_handled;

    // shadow registers and byte count of the predictor
    logic               dir_read    = 1'b0;
    logic               ten_bit     = 1'b0;
    logic [ADDR_W-1:0]  target_addr = '0;
    logic               dma_on      = 1'b0;
    logic [COUNT_W-1:0] xfer_len    = '0;
    logic [COUNT_W-1:0] bytes_left  = '0;

    xfer_req_t queued_requests[$];
    result_t   expected_responses[$];
    xfer_req_t active_req;
    result_t   want_rsp;

    int mismatch_count = 0;
    int items_queued   = 0;
    int quiet_cycles   = 0;
    int src_gap        = 0;
    int snk_gap        = 0;
    int src_idle_pct   = 10;
    int snk_stall_pct  = 10;

    i2c_master_transfer_sequencer DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_start_sent       (s_start_sent),
        .s_address_done     (s_address_done),
        .s_header_done      (s_header_done),
        .s_byte_finished    (s_byte_finished),
        .s_rx_not_empty     (s_rx_not_empty),
        .s_tx_empty         (s_tx_empty),
        .s_transmitter_role (s_transmitter_role),
        .s_rx_byte          (s_rx_byte),
        .s_next_tx_byte     (s_next_tx_byte),
        .s_error_bits       (s_error_bits),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_data_reg   (m_write_data_reg),
        .m_data_value       (m_data_value),
        .m_store_rx         (m_store_rx),
        .m_took_tx          (m_took_tx),
        .m_request_stop     (m_request_stop),
        .m_drop_ack         (m_drop_ack),
        .m_buffer_irq_on    (m_buffer_irq_on),
        .m_events           (m_events),
        .m_handled          (m_handled)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // response prediction
    // ------------------------------------------------------------------------

    // master receive: flags in priority order, several of them end the decode
    function automatic result_t decode_rx_flags(input xfer_req_t rq);
        result_t res;
        res = '0;
        if (rq.start_sent) begin
            res.write_data_reg = 1'b1;
            res.data_value = ten_bit ? (HDR_READ | {5'd0, target_addr[9:8], 1'b0})
                                     : (target_addr[7:0] | 8'h01);
        end
        if (rq.address_done) begin
            if (rq.transmitter_role) begin
                res.events[EV_IO_ERR] = 1'b1;
                return res;
            end
            if (bytes_left == 1) res.drop_ack = 1'b1;
            if (!dma_on) begin
                res.buffer_irq_on = 1'b1;
            end else begin
                res.events[EV_ADDR] = 1'b1;
                res.handled = 1'b1;
                return res;
            end
        end
        // received byte; the count never drops below zero
        if (rq.rx_not_empty) begin
            if (bytes_left != 0) begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0) begin
                    res.drop_ack = 1'b1;
                    res.events[EV_RX] = 1'b1;
                    res.events[EV_IDLE] = 1'b1;
                end
                res.store_rx = 1'b1;
            end
            if (bytes_left == 0) res.request_stop = 1'b1;
            res.handled = 1'b1;
            return res;
        end
        // byte finished stores without touching the count
        if (rq.byte_finished) begin
            if (bytes_left != 0) begin
                res.store_rx = 1'b1;
            end else begin
                res.events[EV_RX] = 1'b1;
                res.handled = 1'b1;
                return res;
            end
        end
        if (rq.tx_empty) begin
            res.events[EV_INVALID] = 1'b1;
            res.handled = 1'b1;
            return res;
        end
        if (rq.header_done) begin
            res.write_data_reg = 1'b1;
            res.data_value = target_addr[7:0];
        end
        return res;
    endfunction

    // master transmit
    function automatic result_t decode_tx_flags(input xfer_req_t rq);
        result_t res;
        res = '0;
        if (rq.start_sent) begin
            res.write_data_reg = 1'b1;
            res.data_value = ten_bit ? (HDR_WRITE | {5'd0, target_addr[9:8], 1'b0})
                                     : {target_addr[7:1], 1'b0};
        end
        if (rq.rx_not_empty) begin
            res.events[EV_INVALID] = 1'b1;
            res.handled = 1'b1;
            return res;
        end
        if (rq.address_done) begin
            if (!rq.transmitter_role) begin
                res.events[EV_IO_ERR] = 1'b1;
                return res;
            end
            if (!dma_on) begin
                res.buffer_irq_on = 1'b1;
            end else begin
                res.events[EV_ADDR] = 1'b1;
                res.handled = 1'b1;
                return res;
            end
        end
        // last byte out, or dma owns the data phase: stop
        if (rq.byte_finished && ((rq.tx_empty && bytes_left == 0) || dma_on)) begin
            res.request_stop = 1'b1;
            res.events[EV_IDLE] = 1'b1;
            res.handled = 1'b1;
            return res;
        end
        if (rq.tx_empty) begin
            if (bytes_left != 0) begin
                bytes_left = bytes_left - 1'b1;
                res.write_data_reg = 1'b1;
                res.data_value = rq.next_tx_byte;
                res.took_tx = 1'b1;
            end else begin
                res.events[EV_TX] = 1'b1;
                res.handled = 1'b1;
                return res;
            end
        end
        // a later data register write overrides an earlier one
        if (rq.header_done) begin
            res.write_data_reg = 1'b1;
            res.data_value = target_addr[7:0];
        end
        return res;
    endfunction

    function automatic result_t predict_response(input xfer_req_t rq);
        result_t res;
        res = '0;
        case (rq.cmd)
            CMD_START: begin
                bytes_left = xfer_len;
            end
            CMD_EVENT: begin
                res = dir_read ? decode_rx_flags(rq) : decode_tx_flags(rq);
            end
            CMD_ERROR: begin
                if (|(rq.error_bits & ERR_IO_MASK)) begin
                    res.events[EV_IO_ERR] = 1'b1;
                    res.handled = 1'b1;
                end else if (|(rq.error_bits & ERR_ACK_MASK)) begin
                    res.request_stop = 1'b1;
                    res.events[EV_IDLE] = 1'b1;
                    res.handled = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------------

    function automatic xfer_req_t make_request(input cmd_t c, input logic [6:0] fl,
                                               input logic [ERRORS_W-1:0] eb);
        xfer_req_t rq;
        rq.cmd = c;
        {rq.start_sent, rq.address_done, rq.header_done, rq.byte_finished,
         rq.rx_not_empty, rq.tx_empty, rq.transmitter_role} = fl;
        rq.rx_byte      = 8'($urandom_range(0, 255));
        rq.next_tx_byte = 8'($urandom_range(0, 255));
        rq.error_bits   = eb;
        return rq;
    endfunction

    function automatic logic [ERRORS_W-1:0] rand_error_bits();
        case ($urandom_range(0, 2))
            0:       return ERR_ACK_MASK;
            1:       return ERR_IO_MASK &
                            (ERRORS_W'(1) << $urandom_range(0, ERR_ACK_FAIL - 1));
            default: return ERRORS_W'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic void push_request(input xfer_req_t rq);
        queued_requests.push_back(rq);
        items_queued++;
    endfunction

    // event request, now and then with one flag flipped
    function automatic void push_event(input logic [6:0] fl);
        if ($urandom_range(0, 99) < 8) fl = fl ^ (7'd1 << $urandom_range(0, 6));
        push_request(make_request(CMD_EVENT, fl, ERRORS_W'($urandom_range(0, 63))));
    endfunction

    function automatic void push_noise();
        push_request(make_request(cmd_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                                  rand_error_bits()));
    endfunction

    // one well-formed transfer for the current register setting
    function automatic void queue_transfer();
        int beats;
        beats = (xfer_len > 16'd8) ? 8 : int'(xfer_len);
        beats = beats + int'($urandom_range(0, 1));
        push_request(make_request(CMD_START, 7'($urandom_range(0, 127)),
                                  ERRORS_W'($urandom_range(0, 63))));
        push_event(FL_START_SENT);
        if (ten_bit) push_event(FL_HDR_DONE);
        push_event(dir_read ? FL_ADDR_DONE : (FL_ADDR_DONE | FL_XMIT_ROLE));
        for (int b = 0; b < beats; b++) begin
            if (dir_read) begin
                push_event(($urandom_range(0, 4) == 0) ? FL_BYTE_FIN : FL_RX_NE);
            end else begin
                push_event(FL_TX_EMPTY | FL_XMIT_ROLE);
            end
            if ($urandom_range(0, 29) == 0) begin
                push_request(make_request(CMD_ERROR, 7'($urandom_range(0, 127)),
                                          rand_error_bits()));
            end
        end
        push_event(dir_read ? FL_BYTE_FIN : (FL_BYTE_FIN | FL_TX_EMPTY | FL_XMIT_ROLE));
    endfunction

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_READ_DIRECTION:  dir_read    = val[0];
            CFG_TEN_BIT_MODE:    ten_bit     = val[0];
            CFG_SLAVE_ADDRESS:   target_addr = val[ADDR_W-1:0];
            CFG_DMA_MODE:        dma_on      = val[0];
            CFG_TRANSFER_LENGTH: xfer_len    = val;
            default: ;
        endcase
    endtask

    // all registers, upper data bits random; optionally the unmapped indexes too
    task automatic write_config(input logic rd, input logic ten, input logic [ADDR_W-1:0] addr,
                                input logic dma, input logic [COUNT_W-1:0] len,
                                input logic unmapped);
        logic [CFG_DATA_W-1:0]  noise;
        logic [CFG_INDEX_W-1:0] idx;
        noise = CFG_DATA_W'($urandom_range(0, 65535));
        write_reg(CFG_READ_DIRECTION, {noise[15:1], rd});
        noise = CFG_DATA_W'($urandom_range(0, 65535));
        write_reg(CFG_TEN_BIT_MODE, {noise[15:1], ten});
        noise = CFG_DATA_W'($urandom_range(0, 65535));
        write_reg(CFG_SLAVE_ADDRESS, {noise[15:ADDR_W], addr});
        noise = CFG_DATA_W'($urandom_range(0, 65535));
        write_reg(CFG_DMA_MODE, {noise[15:1], dma});
        write_reg(CFG_TRANSFER_LENGTH, len);
        if (unmapped) begin
            for (int j = CFG_TRANSFER_LENGTH + 1; j < (1 << CFG_INDEX_W); j++) begin
                idx = CFG_INDEX_W'(j);
                write_reg(idx, CFG_DATA_W'($urandom_range(0, 65535)));
            end
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // everything sent and every response back
    task automatic wait_idle();
        while (queued_requests.size() != 0 || s_valid || expected_responses.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", fname, want, got));
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_responses.push_back(predict_response(active_req));
            end
            // next request once the slot is free
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap = src_gap - 1;
                    s_valid <= 1'b0;
                end else if (queued_requests.size() != 0 && src_idle_pct != 0 &&
                             $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(0, 11);
                    s_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    active_req = queued_requests.pop_front();
                    s_cmd              <= active_req.cmd;
                    s_start_sent       <= active_req.start_sent;
                    s_address_done     <= active_req.address_done;
                    s_header_done      <= active_req.header_done;
                    s_byte_finished    <= active_req.byte_finished;
                    s_rx_not_empty     <= active_req.rx_not_empty;
                    s_tx_empty         <= active_req.tx_empty;
                    s_transmitter_role <= active_req.transmitter_role;
                    s_rx_byte          <= active_req.rx_byte;
                    s_next_tx_byte     <= active_req.next_tx_byte;
                    s_error_bits       <= active_req.error_bits;
                    s_valid            <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    note_failure("response with no request outstanding");
                end else begin
                    want_rsp = expected_responses.pop_front();
                    check_field("write_data_reg", 8'(want_rsp.write_data_reg),
                                8'(m_write_data_reg));
                    check_field("data_value", want_rsp.data_value, m_data_value);
                    check_field("store_rx", 8'(want_rsp.store_rx), 8'(m_store_rx));
                    check_field("took_tx", 8'(want_rsp.took_tx), 8'(m_took_tx));
                    check_field("request_stop", 8'(want_rsp.request_stop),
                                8'(m_request_stop));
                    check_field("drop_ack", 8'(want_rsp.drop_ack), 8'(m_drop_ack));
                    check_field("buffer_irq_on", 8'(want_rsp.buffer_irq_on),
                                8'(m_buffer_irq_on));
                    check_field("events", 8'(want_rsp.events), 8'(m_events));
                    check_field("handled", 8'(want_rsp.handled), 8'(m_handled));
                end
            end
            if (snk_gap != 0) begin
                snk_gap = snk_gap - 1;
                m_ready <= 1'b0;
            end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
                snk_gap = $urandom_range(0, 11);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        xfer_req_t          rq;
        int                 target;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: transmit, 7-bit, address 0, length 0
        push_request(make_request(CMD_UNUSED, 7'h7F, '1));
        push_request(make_request(CMD_START, 7'h7F, '1));
        push_event(FL_TX_EMPTY);
        push_request(make_request(CMD_ERROR, FL_NONE, '1));
        push_request(make_request(CMD_ERROR, FL_NONE, ERR_ACK_MASK));
        push_request(make_request(CMD_ERROR, 7'h7F, '0));
        push_request(make_request(CMD_EVENT, FL_RX_NE, '0));
        push_request(make_request(CMD_EVENT, FL_START_SENT | FL_ADDR_DONE, '0));
        wait_idle();

        // receive, 10-bit, top address, single byte: nack at count one, count floor
        write_config(1'b1, 1'b1, '1, 1'b0, 16'd1, 1'b1);
        push_request(make_request(CMD_START, FL_NONE, '0));
        push_request(make_request(CMD_EVENT, FL_START_SENT, '0));
        push_request(make_request(CMD_EVENT, FL_ADDR_DONE, '0));
        push_request(make_request(CMD_EVENT, FL_RX_NE, '0));
        push_request(make_request(CMD_EVENT, FL_RX_NE, '0));
        push_request(make_request(CMD_EVENT, FL_BYTE_FIN, '0));
        push_request(make_request(CMD_EVENT, FL_TX_EMPTY, '0));
        push_request(make_request(CMD_EVENT, FL_HDR_DONE, '0));
        push_request(make_request(CMD_EVENT, FL_ADDR_DONE | FL_XMIT_ROLE, '0));
        wait_idle();

        // transmit, 10-bit, dma, full length; data write overridden by header
        write_config(1'b0, 1'b1, 10'h200, 1'b1, '1, 1'b0);
        push_request(make_request(CMD_START, FL_NONE, '0));
        push_request(make_request(CMD_EVENT, FL_START_SENT | FL_ADDR_DONE | FL_XMIT_ROLE, '0));
        push_request(make_request(CMD_EVENT, FL_BYTE_FIN, '0));
        rq = make_request(CMD_EVENT, FL_TX_EMPTY | FL_HDR_DONE | FL_XMIT_ROLE, '0);
        rq.next_tx_byte = 8'hFF;
        rq.rx_byte      = 8'hFF;
        push_request(rq);
        wait_idle();

        // receive, 7-bit, dma: byte finished stores while bytes remain
        write_config(1'b1, 1'b0, 10'h0FE, 1'b1, 16'd3, 1'b0);
        push_request(make_request(CMD_START, FL_NONE, '0));
        push_request(make_request(CMD_EVENT, FL_START_SENT | FL_ADDR_DONE, '0));
        push_request(make_request(CMD_EVENT, FL_BYTE_FIN, '0));
        push_request(make_request(CMD_EVENT, FL_NONE, '0));
        wait_idle();

        // random transfers over random settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       addr = '0;
                1:       addr = '1;
                default: addr = ADDR_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = '1;
                default: len = COUNT_W'($urandom_range(1, 6));
            endcase
            write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), addr,
                         $urandom_range(0, 3) == 0, len, $urandom_range(0, 3) == 0);
            if (ph >= RAND_PHASES - CALM_PHASES) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       src_idle_pct = 0;
                    1:       src_idle_pct = 5;
                    2:       src_idle_pct = 20;
                    default: src_idle_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0:       snk_stall_pct = 0;
                    1:       snk_stall_pct = 5;
                    2:       snk_stall_pct = 20;
                    default: snk_stall_pct = 50;
                endcase
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target) begin
                if ($urandom_range(0, 9) < 7) queue_transfer();
                else push_noise();
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
